// ----- rtl/lsnh_pkg.sv -----
`timescale 1ns / 1ps

package lsnh_pkg;

	localparam int CHANNELS = 8;
	localparam int SAMPLES_PER_CHANNEL = 8;
	localparam int LEVEL_W = 12;
	localparam int CH_W = 3;
	localparam int SUM_W = 15;
	localparam int CNT_W = 5;
	localparam int REG_W = 48;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 5;
	localparam int NUM_W = 2 * LEVEL_W;
	localparam int STEP_W = 4;
	localparam int THR_W = 14;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'hFFF;
	localparam logic [CH_W-1:0] LAST_CHANNEL = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0] SAMPLE_LAST = CNT_W'(SAMPLES_PER_CHANNEL - 1);

	typedef enum logic [1:0] {
		REG_WHITE_LO = 2'd0,
		REG_WHITE_HI = 2'd1,
		REG_BLACK_LO = 2'd2,
		REG_BLACK_HI = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [REG_W-1:0] white_lo;
		logic [REG_W-1:0] white_hi;
		logic [REG_W-1:0] black_lo;
		logic [REG_W-1:0] black_hi;
	} cal_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [LEVEL_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [LEVEL_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [LEVEL_W-1:0] level_of(input logic [REG_W-1:0] lo,
			input logic [REG_W-1:0] hi, input logic [CH_W-1:0] ch);
		logic [REG_W-1:0] word;
		begin
			word = ch[2] ? hi : lo;
			level_of = word[LEVEL_W * ch[1:0] +: LEVEL_W];
		end
	endfunction

endpackage

// ----- rtl/lsnh_cfg.sv -----
`timescale 1ns / 1ps

module lsnh_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsnh_pkg::ADDR_W-1:0]   paddr,
	input  logic [lsnh_pkg::DATA_W-1:0]   pwdata,
	output logic [lsnh_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lsnh_pkg::cal_t                cal
);

	lsnh_pkg::cal_t cal_q;
	lsnh_pkg::reg_index_t idx;
	logic [lsnh_pkg::REG_W-1:0] wval;

	assign idx = lsnh_pkg::reg_index_t'(paddr[4:3]);
	assign wval = pwdata[lsnh_pkg::REG_W-1:0];
	assign pready = 1'b1;
	assign cal = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				lsnh_pkg::REG_WHITE_LO: cal_q.white_lo <= wval;
				lsnh_pkg::REG_WHITE_HI: cal_q.white_hi <= wval;
				lsnh_pkg::REG_BLACK_LO: cal_q.black_lo <= wval;
				lsnh_pkg::REG_BLACK_HI: cal_q.black_hi <= wval;
				default: cal_q <= cal_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lsnh_pkg::REG_WHITE_LO: prdata = {16'b0, cal_q.white_lo};
			lsnh_pkg::REG_WHITE_HI: prdata = {16'b0, cal_q.white_hi};
			lsnh_pkg::REG_BLACK_LO: prdata = {16'b0, cal_q.black_lo};
			lsnh_pkg::REG_BLACK_HI: prdata = {16'b0, cal_q.black_hi};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/lsnh_div.sv -----
`timescale 1ns / 1ps

module lsnh_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lsnh_pkg::div_req_t  req,
	output lsnh_pkg::div_rsp_t  rsp
);

	// The quotient is known to fit in twelve bits, so the upper half of the
	// dividend starts as the partial remainder and one bit is resolved per cycle.
	logic [lsnh_pkg::LEVEL_W-1:0] rem_q;
	logic [lsnh_pkg::LEVEL_W-1:0] low_q;
	logic [lsnh_pkg::LEVEL_W-1:0] den_q;
	logic [lsnh_pkg::STEP_W-1:0] step_q;
	logic done_q;
	logic [lsnh_pkg::LEVEL_W:0] trial;
	logic fits;

	assign trial = {rem_q, low_q[lsnh_pkg::LEVEL_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= lsnh_pkg::STEP_W'(lsnh_pkg::LEVEL_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				done_q <= (step_q == lsnh_pkg::STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[lsnh_pkg::NUM_W-1:lsnh_pkg::LEVEL_W];
			low_q <= req.num[lsnh_pkg::LEVEL_W-1:0];
			den_q <= req.den;
		end else if (step_q != '0) begin
			rem_q <= fits ? lsnh_pkg::LEVEL_W'(trial - {1'b0, den_q})
				: trial[lsnh_pkg::LEVEL_W-1:0];
			low_q <= {low_q[lsnh_pkg::LEVEL_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = low_q;

endmodule

// ----- rtl/line_sensor_normalize_hysteresis.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake                      | Payload
// sample   | sample_valid / sample_ready    | adc_sample, conversion_timeout
// result   | result_valid / result_ready    | channel_index .. timeout_total
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A request that does not complete a channel is taken without leaving the idle state.
// A completing request passes through acceptance, select and swap, a range check,
// twelve divider steps, capture of the quotient, and the result load.
// Equal levels or a value at or outside the span skip the divider.
// The load, and with it the input, stalls while the result register is full and not taken.
// Reset clears all counters, hysteresis bits and calibration registers.

module line_sensor_normalize_hysteresis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lsnh_pkg::ADDR_W-1:0]          paddr,
	input  logic [lsnh_pkg::DATA_W-1:0]          pwdata,
	output logic [lsnh_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [lsnh_pkg::LEVEL_W-1:0]         adc_sample,
	input  logic                                 conversion_timeout,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [lsnh_pkg::CH_W-1:0]            channel_index,
	output logic [lsnh_pkg::LEVEL_W-1:0]         raw_average,
	output logic [lsnh_pkg::LEVEL_W-1:0]         normalized_level,
	output logic                                 channel_timed_out,
	output logic [lsnh_pkg::CHANNELS-1:0]        digital_pattern,
	output logic                                 scan_done,
	output logic [31:0]                          scan_number,
	output logic [lsnh_pkg::CHANNELS-1:0]        scan_timeout_mask,
	output logic [31:0]                          timeout_total
);

	lsnh_pkg::cal_t cal;
	lsnh_pkg::div_req_t div_req;
	lsnh_pkg::div_rsp_t div_rsp;
	lsnh_pkg::state_t state_q, state_d;

	logic [lsnh_pkg::SUM_W-1:0] sum_q;
	logic [lsnh_pkg::CNT_W-1:0] count_q;
	logic [lsnh_pkg::CH_W-1:0] chan_q;
	logic [lsnh_pkg::CHANNELS-1:0] dbits_q;
	logic [lsnh_pkg::CHANNELS-1:0] tbits_q;
	logic [31:0] scan_cnt_q;
	logic [31:0] tmo_cnt_q;

	logic [lsnh_pkg::LEVEL_W-1:0] raw_q;
	logic tmo_q;
	logic [lsnh_pkg::LEVEL_W-1:0] w_q;
	logic [lsnh_pkg::LEVEL_W-1:0] b_q;
	logic [lsnh_pkg::LEVEL_W-1:0] norm_q;

	logic out_valid_q;
	logic [lsnh_pkg::CH_W-1:0] out_ch_q;
	logic [lsnh_pkg::LEVEL_W-1:0] out_raw_q;
	logic [lsnh_pkg::LEVEL_W-1:0] out_norm_q;
	logic out_tmo_q;
	logic [lsnh_pkg::CHANNELS-1:0] out_dbits_q;
	logic out_last_q;
	logic [31:0] out_scan_q;
	logic [lsnh_pkg::CHANNELS-1:0] out_mask_q;
	logic [31:0] out_total_q;

	logic accept;
	logic complete;
	logic load;
	logic special;
	logic div_start;
	logic [lsnh_pkg::NUM_W-1:0] div_num;
	logic [lsnh_pkg::LEVEL_W-1:0] div_den;
	logic [lsnh_pkg::SUM_W-1:0] sum_next;
	logic [lsnh_pkg::SUM_W-1:0] mean;
	logic [lsnh_pkg::LEVEL_W-1:0] raw_next;
	logic [lsnh_pkg::LEVEL_W-1:0] w_sel;
	logic [lsnh_pkg::LEVEL_W-1:0] b_sel;
	logic [lsnh_pkg::LEVEL_W-1:0] diff;
	logic [lsnh_pkg::LEVEL_W-1:0] norm_special;
	logic [lsnh_pkg::THR_W-1:0] raw3;
	logic [lsnh_pkg::THR_W-1:0] hi_sum;
	logic [lsnh_pkg::THR_W-1:0] lo_sum;
	logic [lsnh_pkg::CHANNELS-1:0] ch_bit;
	logic [lsnh_pkg::CHANNELS-1:0] dbits_next;
	logic [lsnh_pkg::CHANNELS-1:0] tbits_next;
	logic [31:0] tmo_cnt_next;
	logic [31:0] scan_cnt_next;
	logic last;

	lsnh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	lsnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = sample_valid && sample_ready;
	assign sum_next = sum_q + lsnh_pkg::SUM_W'(adc_sample);
	assign mean = sum_next / lsnh_pkg::SUM_W'(lsnh_pkg::SAMPLES_PER_CHANNEL);
	assign raw_next = (mean > lsnh_pkg::SUM_W'(lsnh_pkg::LEVEL_MAX)) ? lsnh_pkg::LEVEL_MAX
		: mean[lsnh_pkg::LEVEL_W-1:0];
	assign complete = conversion_timeout || (count_q == lsnh_pkg::SAMPLE_LAST);

	assign w_sel = lsnh_pkg::level_of(cal.white_lo, cal.white_hi, chan_q);
	assign b_sel = lsnh_pkg::level_of(cal.black_lo, cal.black_hi, chan_q);

	// Values at or outside the calibration span saturate without dividing.
	assign diff = raw_q - b_q;
	always_comb begin
		special = 1'b1;
		norm_special = '0;
		if (w_q == b_q || raw_q <= b_q) begin
			norm_special = '0;
		end else if (raw_q >= w_q) begin
			norm_special = lsnh_pkg::LEVEL_MAX;
		end else begin
			special = 1'b0;
		end
	end

	assign div_num = {diff, {lsnh_pkg::LEVEL_W{1'b0}}} - lsnh_pkg::NUM_W'(diff);
	assign div_den = w_q - b_q;
	assign div_req = {div_start, div_num, div_den};

	// The thresholds divide by three; comparing against three times the raw value
	// gives the same decisions without a divider.
	assign raw3 = lsnh_pkg::THR_W'(raw_q) + {1'b0, raw_q, 1'b0};
	assign hi_sum = lsnh_pkg::THR_W'(b_q) + {1'b0, w_q, 1'b0};
	assign lo_sum = lsnh_pkg::THR_W'(w_q) + {1'b0, b_q, 1'b0};
	assign ch_bit = lsnh_pkg::CHANNELS'(1) << chan_q;

	always_comb begin
		dbits_next = dbits_q;
		if (w_q != b_q) begin
			if (raw3 + lsnh_pkg::THR_W'(2) >= hi_sum) begin
				dbits_next = dbits_q | ch_bit;
			end else if (raw3 <= lo_sum) begin
				dbits_next = dbits_q & ~ch_bit;
			end
		end
	end

	assign tbits_next = tmo_q ? (tbits_q | ch_bit) : tbits_q;
	assign tmo_cnt_next = tmo_q ? tmo_cnt_q + 32'd1 : tmo_cnt_q;
	assign scan_cnt_next = scan_cnt_q + 32'd1;
	assign last = (chan_q >= lsnh_pkg::LAST_CHANNEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsnh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sample_ready = 1'b0;
		div_start = 1'b0;
		load = 1'b0;
		unique case (state_q)
			lsnh_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid && complete) begin
					state_d = lsnh_pkg::ST_PREP;
				end
			end
			lsnh_pkg::ST_PREP: begin
				state_d = lsnh_pkg::ST_CHECK;
			end
			lsnh_pkg::ST_CHECK: begin
				if (special) begin
					state_d = lsnh_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d = lsnh_pkg::ST_DIV;
				end
			end
			lsnh_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = lsnh_pkg::ST_DONE;
				end
			end
			lsnh_pkg::ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					load = 1'b1;
					state_d = lsnh_pkg::ST_IDLE;
				end
			end
			default: state_d = lsnh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			chan_q <= '0;
			dbits_q <= '0;
			tbits_q <= '0;
			scan_cnt_q <= '0;
			tmo_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (complete) begin
					sum_q <= '0;
					count_q <= '0;
				end else begin
					sum_q <= sum_next;
					count_q <= count_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
				dbits_q <= dbits_next;
				tmo_cnt_q <= tmo_cnt_next;
				if (last) begin
					scan_cnt_q <= scan_cnt_next;
					tbits_q <= '0;
					chan_q <= '0;
				end else begin
					tbits_q <= tbits_next;
					chan_q <= chan_q + 1'b1;
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && complete) begin
			raw_q <= conversion_timeout ? '0 : raw_next;
			tmo_q <= conversion_timeout;
		end
		if (state_q == lsnh_pkg::ST_PREP) begin
			w_q <= (w_sel < b_sel) ? b_sel : w_sel;
			b_q <= (w_sel < b_sel) ? w_sel : b_sel;
		end
		if (state_q == lsnh_pkg::ST_CHECK) begin
			norm_q <= norm_special;
		end else if (state_q == lsnh_pkg::ST_DIV && div_rsp.done) begin
			norm_q <= div_rsp.quo;
		end
		if (load) begin
			out_ch_q <= chan_q;
			out_raw_q <= raw_q;
			out_norm_q <= norm_q;
			out_tmo_q <= tmo_q;
			out_dbits_q <= dbits_next;
			out_last_q <= last;
			out_scan_q <= last ? scan_cnt_next : '0;
			out_mask_q <= last ? tbits_next : '0;
			out_total_q <= tmo_cnt_next;
		end
	end

	assign result_valid = out_valid_q;
	assign channel_index = out_ch_q;
	assign raw_average = out_raw_q;
	assign normalized_level = out_norm_q;
	assign channel_timed_out = out_tmo_q;
	assign digital_pattern = out_dbits_q;
	assign scan_done = out_last_q;
	assign scan_number = out_scan_q;
	assign scan_timeout_mask = out_mask_q;
	assign timeout_total = out_total_q;

endmodule
